/* sv/dpp_pkg.sv */
// shared types, constants and register codes for the depth pixel projection core
// no dependencies
package dpp_pkg;

	// default frame size limits
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// configuration port widths
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	// fixed field widths
	localparam int SIZE_W   = 11;
	localparam int SCALE_W  = 16;
	localparam int DEPTH_W  = 32;
	localparam int RAW_W    = 16;
	localparam int COLOUR_W = 8;
	localparam int COORD_W  = 43;
	localparam int RANGE_W  = 33;

	// fractional bits dropped after the lateral product
	localparam int LAT_SHIFT = 17;

	// register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH     = 3'd0,
		REG_FRAME_HEIGHT    = 3'd1,
		REG_DEPTH_SCALE     = 3'd2,
		REG_LATERAL_SCALE_X = 3'd3,
		REG_LATERAL_SCALE_Y = 3'd4,
		REG_NEAR_LIMIT      = 3'd5,
		REG_FAR_LIMIT       = 3'd6
	} cfg_reg_e;

	// configuration register contents
	typedef struct packed {
		logic [SIZE_W-1:0]  frame_width;
		logic [SIZE_W-1:0]  frame_height;
		logic [SCALE_W-1:0] depth_scale;
		logic [SCALE_W-1:0] lateral_scale_x;
		logic [SCALE_W-1:0] lateral_scale_y;
		logic [DEPTH_W-1:0] near_limit;
		logic [DEPTH_W-1:0] far_limit;
	} cfg_t;

endpackage

/* sv/dpp_front.sv */
// front part: accepts pixels, keeps the raster counters, scales the depth
// and works out the half-pixel offsets from the image centre; uses dpp_pkg
module dpp_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int XW = $clog2(MAX_WIDTH) + 2,
	parameter int YW = $clog2(MAX_HEIGHT) + 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dpp_pkg::cfg_t           cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [15:0]             raw_depth,
	input  logic [7:0]              red_in,
	input  logic [7:0]              green_in,
	input  logic [7:0]              blue_in,
	output logic                    push_valid,
	input  logic                    push_ready,
	output logic [31:0]             item_z,
	output logic [XW-1:0]           item_dx_mag,
	output logic                    item_dx_neg,
	output logic [YW-1:0]           item_dy_mag,
	output logic                    item_dy_neg,
	output logic [7:0]              item_red,
	output logic [7:0]              item_green,
	output logic [7:0]              item_blue,
	output logic                    item_frame_end
);
	import dpp_pkg::*;

	localparam int CWX = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CWY = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int SWX = $clog2(MAX_WIDTH + 1);
	localparam int SWY = $clog2(MAX_HEIGHT + 1);
	localparam int EWX = (SWX > SIZE_W) ? SWX : SIZE_W;
	localparam int EWY = (SWY > SIZE_W) ? SWY : SIZE_W;

	logic [CWX-1:0] col_q;
	logic [CWY-1:0] row_q;
	logic [EWX-1:0] fw_x, w_eff, cx, col_x, diff_x;
	logic [EWY-1:0] fh_x, h_eff, cy, row_x, diff_y;
	logic           last_col, last_row, accept;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	// effective frame size: zero taken as one, clipped to the maximum
	always_comb begin
		fw_x = EWX'(cfg.frame_width);
		fh_x = EWY'(cfg.frame_height);
		if (fw_x == '0) begin
			w_eff = EWX'(1);
		end else if (fw_x > EWX'(MAX_WIDTH)) begin
			w_eff = EWX'(MAX_WIDTH);
		end else begin
			w_eff = fw_x;
		end
		if (fh_x == '0) begin
			h_eff = EWY'(1);
		end else if (fh_x > EWY'(MAX_HEIGHT)) begin
			h_eff = EWY'(MAX_HEIGHT);
		end else begin
			h_eff = fh_x;
		end
	end

	// end of row and end of frame
	assign col_x    = EWX'(col_q);
	assign row_x    = EWY'(row_q);
	assign last_col = ({1'b0, col_x} + (EWX+1)'(1)) >= {1'b0, w_eff};
	assign last_row = ({1'b0, row_x} + (EWY+1)'(1)) >= {1'b0, h_eff};

	// offset from centre in half pixels, d = 2*pos - 2*centre - 1, as sign and magnitude
	always_comb begin
		cx = w_eff >> 1;
		cy = h_eff >> 1;
		if (col_x > cx) begin
			diff_x      = col_x - cx;
			item_dx_neg = 1'b0;
			item_dx_mag = XW'({diff_x, 1'b0}) - XW'(1);
		end else begin
			diff_x      = cx - col_x;
			item_dx_neg = 1'b1;
			item_dx_mag = XW'({diff_x, 1'b0}) + XW'(1);
		end
		if (row_x > cy) begin
			diff_y      = row_x - cy;
			item_dy_neg = 1'b0;
			item_dy_mag = YW'({diff_y, 1'b0}) - YW'(1);
		end else begin
			diff_y      = cy - row_x;
			item_dy_neg = 1'b1;
			item_dy_mag = YW'({diff_y, 1'b0}) + YW'(1);
		end
	end

	// scaled depth and pass-through fields
	assign item_z         = 32'(raw_depth) * 32'(cfg.depth_scale);
	assign item_red       = red_in;
	assign item_green     = green_in;
	assign item_blue      = blue_in;
	assign item_frame_end = last_col && last_row;

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + CWY'(1);
				end
			end else begin
				col_q <= col_q + CWX'(1);
			end
		end
	end

endmodule

/* sv/dpp_queue.sv */
// small register queue between the front and back parts
// no dependencies
module dpp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q != NW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

/* sv/dpp_back.sv */
// back part: depth window test, lateral products, rounding, negation and
// saturation over three stages with an output register; uses dpp_pkg
module dpp_back #(
	parameter int XW = 12,
	parameter int YW = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dpp_pkg::cfg_t       cfg,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [31:0]         item_z,
	input  logic [XW-1:0]       item_dx_mag,
	input  logic                item_dx_neg,
	input  logic [YW-1:0]       item_dy_mag,
	input  logic                item_dy_neg,
	input  logic [7:0]          item_red,
	input  logic [7:0]          item_green,
	input  logic [7:0]          item_blue,
	input  logic                item_frame_end,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [42:0]  point_x,
	output logic signed [32:0]  point_y,
	output logic signed [42:0]  point_z,
	output logic [7:0]          red_out,
	output logic [7:0]          green_out,
	output logic [7:0]          blue_out,
	output logic                in_window,
	output logic                frame_end
);
	import dpp_pkg::*;

	localparam int PXW = XW + SCALE_W;
	localparam int PYW = YW + SCALE_W;
	localparam int MXW = PXW + DEPTH_W;
	localparam int MYW = PYW + DEPTH_W;

	// rounded quotient by 2^17, negated and saturated to 43 bits
	function automatic logic [COORD_W-1:0] sat_lateral(logic [63:0] mag, logic neg);
		logic [63:0] q;
		logic [COORD_W-1:0] r;
		if (neg) begin
			q = (mag + 64'h1FFFF) >> LAT_SHIFT;
			if (q > 64'h3FF_FFFF_FFFF) begin
				r = {1'b0, {(COORD_W-1){1'b1}}};
			end else begin
				r = COORD_W'(q);
			end
		end else begin
			q = mag >> LAT_SHIFT;
			if (q > 64'h400_0000_0000) begin
				r = {1'b1, {(COORD_W-1){1'b0}}};
			end else begin
				r = COORD_W'(64'd0 - q);
			end
		end
		return r;
	endfunction

	logic             v_s1, v_s2, v_s3, stall;
	logic [31:0]      z_s1, z_s2;
	logic             ok_s1, ok_s2;
	logic [PXW-1:0]   px_s1;
	logic [PYW-1:0]   py_s1;
	logic [MXW-1:0]   mx_s2;
	logic [MYW-1:0]   my_s2;
	logic             xn_s1, yn_s1, xn_s2, yn_s2, fe_s1, fe_s2;
	logic [7:0]       r_s1, g_s1, b_s1, r_s2, g_s2, b_s2;
	logic             ok_in;

	assign stall      = v_s3 && !out_ready;
	assign item_ready = !stall;
	assign out_valid  = v_s3;
	assign ok_in      = (item_z >= cfg.near_limit) && (item_z <= cfg.far_limit);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: window test, offset times lateral scale
	always_ff @(posedge clk) begin
		if (!stall) begin
			z_s1  <= item_z;
			ok_s1 <= ok_in;
			px_s1 <= PXW'(item_dx_mag) * PXW'(cfg.lateral_scale_x);
			py_s1 <= PYW'(item_dy_mag) * PYW'(cfg.lateral_scale_y);
			xn_s1 <= item_dx_neg;
			yn_s1 <= item_dy_neg;
			r_s1  <= item_red;
			g_s1  <= item_green;
			b_s1  <= item_blue;
			fe_s1 <= item_frame_end;
		end
	end

	// stage 2: times scaled depth
	always_ff @(posedge clk) begin
		if (!stall) begin
			z_s2  <= z_s1;
			ok_s2 <= ok_s1;
			mx_s2 <= MXW'(px_s1) * MXW'(z_s1);
			my_s2 <= MYW'(py_s1) * MYW'(z_s1);
			xn_s2 <= xn_s1;
			yn_s2 <= yn_s1;
			r_s2  <= r_s1;
			g_s2  <= g_s1;
			b_s2  <= b_s1;
			fe_s2 <= fe_s1;
		end
	end

	// stage 3: output register, origin and black when outside the window
	always_ff @(posedge clk) begin
		if (!stall) begin
			if (ok_s2) begin
				point_x   <= sat_lateral(64'(mx_s2), xn_s2);
				point_z   <= sat_lateral(64'(my_s2), yn_s2);
				point_y   <= RANGE_W'(0) - {1'b0, z_s2};
				red_out   <= r_s2;
				green_out <= g_s2;
				blue_out  <= b_s2;
			end else begin
				point_x   <= '0;
				point_z   <= '0;
				point_y   <= '0;
				red_out   <= '0;
				green_out <= '0;
				blue_out  <= '0;
			end
			in_window <= ok_s2;
			frame_end <= fe_s2;
		end
	end

endmodule

/* sv/depth_pixel_to_point_projection_core.sv */
// depth pixel to point projection: one point per pixel, throughput one pixel per cycle
// while out_ready does not stall the output; an input transaction passes the queue and
// then the window/scale, depth product and saturation stages of the back part
// a four entry queue decouples input from output stalls
// reset clears counters, queue and stage valids and loads the register defaults
// uses dpp_pkg, dpp_front, dpp_queue, dpp_back
module depth_pixel_to_point_projection_core #(
	parameter int MAX_WIDTH  = dpp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dpp_pkg::MAX_HEIGHT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         raw_depth,
	input  logic [7:0]          red_in,
	input  logic [7:0]          green_in,
	input  logic [7:0]          blue_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [42:0]  point_x,
	output logic signed [32:0]  point_y,
	output logic signed [42:0]  point_z,
	output logic [7:0]          red_out,
	output logic [7:0]          green_out,
	output logic [7:0]          blue_out,
	output logic                in_window,
	output logic                frame_end
);
	import dpp_pkg::*;

	localparam int XW     = $clog2(MAX_WIDTH) + 2;
	localparam int YW     = $clog2(MAX_HEIGHT) + 2;
	localparam int ITEM_W = DEPTH_W + XW + 1 + YW + 1 + 3 * COLOUR_W + 1;

	cfg_t            cfg_q;
	logic            push_valid, push_ready, pop_valid, pop_ready;
	logic [ITEM_W-1:0] push_data, pop_data;

	logic [31:0]     f_z, b_z;
	logic [XW-1:0]   f_dx_mag, b_dx_mag;
	logic [YW-1:0]   f_dy_mag, b_dy_mag;
	logic            f_dx_neg, f_dy_neg, f_fe, b_dx_neg, b_dy_neg, b_fe;
	logic [7:0]      f_r, f_g, f_b, b_r, b_g, b_b;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width     <= SIZE_W'(640);
			cfg_q.frame_height    <= SIZE_W'(480);
			cfg_q.depth_scale     <= SCALE_W'(4);
			cfg_q.lateral_scale_x <= SCALE_W'(111);
			cfg_q.lateral_scale_y <= SCALE_W'(111);
			cfg_q.near_limit      <= '0;
			cfg_q.far_limit       <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_FRAME_WIDTH:     cfg_q.frame_width     <= cfg_data[SIZE_W-1:0];
				REG_FRAME_HEIGHT:    cfg_q.frame_height    <= cfg_data[SIZE_W-1:0];
				REG_DEPTH_SCALE:     cfg_q.depth_scale     <= cfg_data[SCALE_W-1:0];
				REG_LATERAL_SCALE_X: cfg_q.lateral_scale_x <= cfg_data[SCALE_W-1:0];
				REG_LATERAL_SCALE_Y: cfg_q.lateral_scale_y <= cfg_data[SCALE_W-1:0];
				REG_NEAR_LIMIT:      cfg_q.near_limit      <= cfg_data;
				REG_FAR_LIMIT:       cfg_q.far_limit       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front part
	dpp_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.XW         (XW),
		.YW         (YW)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.raw_depth      (raw_depth),
		.red_in         (red_in),
		.green_in       (green_in),
		.blue_in        (blue_in),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.item_z         (f_z),
		.item_dx_mag    (f_dx_mag),
		.item_dx_neg    (f_dx_neg),
		.item_dy_mag    (f_dy_mag),
		.item_dy_neg    (f_dy_neg),
		.item_red       (f_r),
		.item_green     (f_g),
		.item_blue      (f_b),
		.item_frame_end (f_fe)
	);

	assign push_data = {f_z, f_dx_mag, f_dx_neg, f_dy_mag, f_dy_neg, f_r, f_g, f_b, f_fe};

	// queue between the parts
	dpp_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign {b_z, b_dx_mag, b_dx_neg, b_dy_mag, b_dy_neg, b_r, b_g, b_b, b_fe} = pop_data;

	// back part
	dpp_back #(
		.XW (XW),
		.YW (YW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.item_valid     (pop_valid),
		.item_ready     (pop_ready),
		.item_z         (b_z),
		.item_dx_mag    (b_dx_mag),
		.item_dx_neg    (b_dx_neg),
		.item_dy_mag    (b_dy_mag),
		.item_dy_neg    (b_dy_neg),
		.item_red       (b_r),
		.item_green     (b_g),
		.item_blue      (b_b),
		.item_frame_end (b_fe),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.point_x        (point_x),
		.point_y        (point_y),
		.point_z        (point_z),
		.red_out        (red_out),
		.green_out      (green_out),
		.blue_out       (blue_out),
		.in_window      (in_window),
		.frame_end      (frame_end)
	);

endmodule
